[src/mpoe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpoe_pkg: shared definitions for the primary-opcode execute block
// opcode codes, field widths, stream packing widths and inter-module structs
// ----------------------------------------------------------------------------
package mpoe_pkg;

    localparam int MPOE_DATA_WORDS = 1024;

    localparam int XLEN        = 32;
    localparam int RF_ADDR_W   = 5;
    localparam int RF_DEPTH    = 32;
    localparam int OPC_W       = 6;
    localparam int MASK_W      = 4;
    localparam int WORD_ADDR_W = 30;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 144;

    // primary opcodes
    localparam logic [OPC_W-1:0] OP_REGIMM = 6'h01;
    localparam logic [OPC_W-1:0] OP_J      = 6'h02;
    localparam logic [OPC_W-1:0] OP_JAL    = 6'h03;
    localparam logic [OPC_W-1:0] OP_BEQ    = 6'h04;
    localparam logic [OPC_W-1:0] OP_BNE    = 6'h05;
    localparam logic [OPC_W-1:0] OP_BLEZ   = 6'h06;
    localparam logic [OPC_W-1:0] OP_BGTZ   = 6'h07;
    localparam logic [OPC_W-1:0] OP_ADDI   = 6'h08;
    localparam logic [OPC_W-1:0] OP_ADDIU  = 6'h09;
    localparam logic [OPC_W-1:0] OP_SLTI   = 6'h0A;
    localparam logic [OPC_W-1:0] OP_SLTIU  = 6'h0B;
    localparam logic [OPC_W-1:0] OP_ANDI   = 6'h0C;
    localparam logic [OPC_W-1:0] OP_ORI    = 6'h0D;
    localparam logic [OPC_W-1:0] OP_XORI   = 6'h0E;
    localparam logic [OPC_W-1:0] OP_LUI    = 6'h0F;
    localparam logic [OPC_W-1:0] OP_LB     = 6'h20;
    localparam logic [OPC_W-1:0] OP_LH     = 6'h21;
    localparam logic [OPC_W-1:0] OP_LWL    = 6'h22;
    localparam logic [OPC_W-1:0] OP_LW     = 6'h23;
    localparam logic [OPC_W-1:0] OP_LBU    = 6'h24;
    localparam logic [OPC_W-1:0] OP_LHU    = 6'h25;
    localparam logic [OPC_W-1:0] OP_LWR    = 6'h26;
    localparam logic [OPC_W-1:0] OP_SB     = 6'h28;
    localparam logic [OPC_W-1:0] OP_SH     = 6'h29;
    localparam logic [OPC_W-1:0] OP_SWL    = 6'h2A;
    localparam logic [OPC_W-1:0] OP_SW     = 6'h2B;
    localparam logic [OPC_W-1:0] OP_SWR    = 6'h2E;

    localparam logic [RF_ADDR_W-1:0] LINK_REG         = 5'd31;
    localparam logic [RF_ADDR_W-1:0] REGIMM_LINK_MASK = 5'h1E;
    localparam logic [RF_ADDR_W-1:0] REGIMM_LINK_CODE = 5'h10;
    localparam logic [XLEN-1:0]      JUMP_REGION_MASK = 32'hF000_0000;

    typedef struct packed {
        logic                 en;
        logic [RF_ADDR_W-1:0] addr;
        logic [XLEN-1:0]      data;
    } rf_wr_t;

    typedef struct packed {
        logic            en;
        logic [XLEN-1:0] data;
    } dm_wr_t;

    typedef struct packed {
        logic                   valid;
        logic [WORD_ADDR_W-1:0] word;
    } dm_req_t;

    typedef struct packed {
        logic                 unknown_opcode;
        logic [MASK_W-1:0]    mem_byte_mask;
        logic [XLEN-1:0]      mem_write_data;
        logic [XLEN-1:0]      mem_address;
        logic                 mem_write_enable;
        logic [XLEN-1:0]      branch_target;
        logic                 branch_taken;
        logic [XLEN-1:0]      reg_write_value;
        logic [RF_ADDR_W-1:0] reg_write_index;
        logic                 reg_write_enable;
    } result_t;

    function automatic logic is_memop(input logic [OPC_W-1:0] op);
        return (op == OP_LB) || (op == OP_LH) || (op == OP_LWL) || (op == OP_LW) ||
               (op == OP_LBU) || (op == OP_LHU) || (op == OP_LWR) || (op == OP_SB) ||
               (op == OP_SH) || (op == OP_SWL) || (op == OP_SW) || (op == OP_SWR);
    endfunction

endpackage

[src/mpoe_regfile.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpoe_regfile: general register file
// two registered read ports, one write port, write-through on a same-edge
// hit, per-entry valid bits so that unwritten registers read zero
// ----------------------------------------------------------------------------
module mpoe_regfile
    import mpoe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [RF_ADDR_W-1:0] rd_addr_a,
    input  logic [RF_ADDR_W-1:0] rd_addr_b,
    input  rf_wr_t               wr,
    output logic [XLEN-1:0]      rd_data_a,
    output logic [XLEN-1:0]      rd_data_b
);

    logic [XLEN-1:0]     mem [RF_DEPTH];
    logic [RF_DEPTH-1:0] valid_reg;
    logic [XLEN-1:0]     q_a_reg;
    logic [XLEN-1:0]     q_b_reg;
    logic [XLEN-1:0]     byp_data_reg;
    logic                vld_a_reg;
    logic                vld_b_reg;
    logic                byp_a_reg;
    logic                byp_b_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            q_a_reg <= mem[rd_addr_a];
            q_b_reg <= mem[rd_addr_b];
            byp_data_reg <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            byp_a_reg <= 1'b0;
            byp_b_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en) begin
                vld_a_reg <= valid_reg[rd_addr_a];
                vld_b_reg <= valid_reg[rd_addr_b];
                byp_a_reg <= wr.en && (wr.addr == rd_addr_a);
                byp_b_reg <= wr.en && (wr.addr == rd_addr_b);
            end
        end
    end

    assign rd_data_a = byp_a_reg ? byp_data_reg : (vld_a_reg ? q_a_reg : '0);
    assign rd_data_b = byp_b_reg ? byp_data_reg : (vld_b_reg ? q_b_reg : '0);

endmodule

[src/mpoe_dmem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpoe_dmem: data memory
// single-port word memory with clearing sweep after reset, word index reduction
// modulo a non-power-of-two depth by reciprocal multiplication in a multiply
// state and a subtract state, registered read and write-back to the last read word
// ----------------------------------------------------------------------------
module mpoe_dmem
    import mpoe_pkg::*;
#(
    parameter int DATA_WORDS = MPOE_DATA_WORDS
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  dm_req_t         req,
    input  dm_wr_t          wr,
    output logic            clearing,
    output logic            rd_ready,
    output logic [XLEN-1:0] rd_data
);

    localparam int IDX_W   = $clog2(DATA_WORDS);
    localparam bit IS_POW2 = (DATA_WORDS & (DATA_WORDS - 1)) == 0;

    // floor(x / DATA_WORDS) == (x * RCP) >> RCP_SHIFT for every 30-bit x
    localparam int     RCP_SHIFT = WORD_ADDR_W + IDX_W;
    localparam longint RCP_L     = ((longint'(1) << RCP_SHIFT) + longint'(DATA_WORDS) - 1)
                                 / longint'(DATA_WORDS);
    localparam logic [WORD_ADDR_W:0] RCP = (WORD_ADDR_W+1)'(RCP_L);
    localparam int     PROD_W    = 2 * WORD_ADDR_W + 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_MUL   = 2'd2;
    localparam logic [1:0] ST_SUB   = 2'd3;

    logic [XLEN-1:0]        mem [DATA_WORDS];
    logic [XLEN-1:0]        q_reg;

    logic [1:0]             state_reg, state_next;
    logic [IDX_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [WORD_ADDR_W-1:0] num_reg, num_next;
    logic [WORD_ADDR_W-1:0] quo_reg, quo_next;
    logic                   ready_reg, ready_next;

    logic [PROD_W-1:0]      prod;
    logic [WORD_ADDR_W-1:0] quo_step;
    logic [WORD_ADDR_W-1:0] rem_full;
    logic [IDX_W-1:0]       rem_idx;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_idx;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [XLEN-1:0]        mem_wdata;

    // quotient by reciprocal, then remainder by constant multiply and subtract
    assign prod     = PROD_W'(num_reg) * PROD_W'(RCP);
    assign quo_step = WORD_ADDR_W'(prod >> RCP_SHIFT);
    assign rem_full = num_reg - quo_reg * WORD_ADDR_W'(DATA_WORDS);
    assign rem_idx  = rem_full[IDX_W-1:0];

    always_comb begin
        rd_en  = 1'b0;
        rd_idx = req.word[IDX_W-1:0];
        if (state_reg == ST_IDLE && req.valid && IS_POW2) begin
            rd_en = 1'b1;
        end
        if (state_reg == ST_SUB) begin
            rd_en  = 1'b1;
            rd_idx = rem_idx;
        end
    end

    assign mem_we    = (state_reg == ST_CLEAR) || wr.en;
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : idx_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : wr.data;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            q_reg <= mem[rd_idx];
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        idx_next     = idx_reg;
        num_next     = num_reg;
        quo_next     = quo_reg;
        ready_next   = ready_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(DATA_WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (req.valid) begin
                    if (IS_POW2) begin
                        idx_next   = rd_idx;
                        ready_next = 1'b1;
                    end else begin
                        num_next   = req.word;
                        ready_next = 1'b0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                quo_next   = quo_step;
                state_next = ST_SUB;
            end
            ST_SUB: begin
                idx_next   = rem_idx;
                ready_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            ready_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            ready_reg   <= ready_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
    end

    assign clearing = (state_reg == ST_CLEAR);
    assign rd_ready = ready_reg;
    assign rd_data  = q_reg;

endmodule

[src/mpoe_exec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpoe_exec: execute datapath
// decodes one instruction against its operands and the addressed memory
// word, forms the register write, branch, and merged store word
// ----------------------------------------------------------------------------
module mpoe_exec
    import mpoe_pkg::*;
(
    input  logic [XLEN-1:0] instruction,
    input  logic [XLEN-1:0] pc,
    input  logic [XLEN-1:0] reg_a,
    input  logic [XLEN-1:0] reg_b,
    input  logic [XLEN-1:0] mem_word,
    input  logic            cache_isolated,
    output result_t         result
);

    logic [OPC_W-1:0]     op;
    logic [RF_ADDR_W-1:0] rt;
    logic [15:0]          imm;
    logic [XLEN-1:0]      imm_z;
    logic [XLEN-1:0]      simm;
    logic [XLEN-1:0]      addr;
    logic [XLEN-1:0]      btarget;
    logic [XLEN-1:0]      link;
    logic [4:0]           sh8;
    logic [4:0]           sh8_inv;
    logic [4:0]           sh16;
    logic [XLEN-1:0]      byte_v;
    logic [XLEN-1:0]      half_v;

    logic                 wr;
    logic [RF_ADDR_W-1:0] widx;
    logic [XLEN-1:0]      wval;
    logic                 br;
    logic [XLEN-1:0]      tgt;
    logic                 memop;
    logic                 unk;
    logic [MASK_W-1:0]    lanes;
    logic [XLEN-1:0]      sdata;
    logic [XLEN-1:0]      bit_mask;
    logic [XLEN-1:0]      mdata;
    logic                 wr_final;
    logic                 mw;

    assign op      = instruction[31:26];
    assign rt      = instruction[20:16];
    assign imm     = instruction[15:0];
    assign imm_z   = {16'h0000, imm};
    assign simm    = {{16{imm[15]}}, imm};
    assign addr    = reg_a + simm;
    assign btarget = pc + 32'd4 + {simm[29:0], 2'b00};
    assign link    = pc + 32'd8;
    assign sh8     = {addr[1:0], 3'b000};
    assign sh8_inv = 5'd24 - sh8;
    assign sh16    = {addr[1], 4'b0000};
    assign byte_v  = mem_word >> sh8;
    assign half_v  = mem_word >> sh16;

    always_comb begin
        wr    = 1'b0;
        widx  = rt;
        wval  = '0;
        br    = 1'b0;
        tgt   = '0;
        memop = 1'b0;
        unk   = 1'b0;
        lanes = '0;
        sdata = '0;
        unique case (op)
            OP_REGIMM: begin
                // rt bit 0 picks ge, link when rt is 0x10 or 0x11
                if (reg_a[31] != rt[0]) begin
                    br  = 1'b1;
                    tgt = btarget;
                end
                if ((rt & REGIMM_LINK_MASK) == REGIMM_LINK_CODE) begin
                    wr   = 1'b1;
                    widx = LINK_REG;
                    wval = link;
                end
            end
            OP_J, OP_JAL: begin
                br  = 1'b1;
                tgt = (pc & JUMP_REGION_MASK) | {4'b0000, instruction[25:0], 2'b00};
                if (op == OP_JAL) begin
                    wr   = 1'b1;
                    widx = LINK_REG;
                    wval = link;
                end
            end
            OP_BEQ: begin
                if (reg_a == reg_b) begin
                    br  = 1'b1;
                    tgt = btarget;
                end
            end
            OP_BNE: begin
                if (reg_a != reg_b) begin
                    br  = 1'b1;
                    tgt = btarget;
                end
            end
            OP_BLEZ: begin
                if (reg_a[31] || reg_a == '0) begin
                    br  = 1'b1;
                    tgt = btarget;
                end
            end
            OP_BGTZ: begin
                if (!reg_a[31] && reg_a != '0) begin
                    br  = 1'b1;
                    tgt = btarget;
                end
            end
            OP_ADDI, OP_ADDIU: begin
                wr   = 1'b1;
                wval = addr;
            end
            OP_SLTI: begin
                wr   = 1'b1;
                wval = {31'b0, $signed(reg_a) < $signed(simm)};
            end
            OP_SLTIU: begin
                wr   = 1'b1;
                wval = {31'b0, reg_a < simm};
            end
            OP_ANDI: begin
                wr   = 1'b1;
                wval = reg_a & imm_z;
            end
            OP_ORI: begin
                wr   = 1'b1;
                wval = reg_a | imm_z;
            end
            OP_XORI: begin
                wr   = 1'b1;
                wval = reg_a ^ imm_z;
            end
            OP_LUI: begin
                wr   = 1'b1;
                wval = {imm, 16'h0000};
            end
            OP_LB, OP_LBU: begin
                memop = 1'b1;
                wr    = !cache_isolated;
                wval  = (op == OP_LB) ? {{24{byte_v[7]}}, byte_v[7:0]}
                                      : {24'h000000, byte_v[7:0]};
            end
            OP_LH, OP_LHU: begin
                memop = 1'b1;
                wr    = !cache_isolated;
                wval  = (op == OP_LH) ? {{16{half_v[15]}}, half_v[15:0]}
                                      : {16'h0000, half_v[15:0]};
            end
            OP_LW: begin
                memop = 1'b1;
                wr    = !cache_isolated;
                wval  = mem_word;
            end
            OP_LWL: begin
                // unaligned loads act even when isolated
                memop = 1'b1;
                wr    = 1'b1;
                wval  = (reg_b & (32'h00FF_FFFF >> sh8)) | (mem_word << sh8_inv);
            end
            OP_LWR: begin
                memop = 1'b1;
                wr    = 1'b1;
                wval  = (reg_b & (32'hFFFF_FF00 << sh8_inv)) | (mem_word >> sh8);
            end
            OP_SB: begin
                memop = 1'b1;
                if (!cache_isolated) begin
                    lanes = MASK_W'(5'd1 << addr[1:0]);
                    sdata = reg_b << sh8;
                end
            end
            OP_SH: begin
                memop = 1'b1;
                if (!cache_isolated) begin
                    lanes = addr[1] ? 4'b1100 : 4'b0011;
                    sdata = reg_b << sh16;
                end
            end
            OP_SW: begin
                memop = 1'b1;
                if (!cache_isolated) begin
                    lanes = 4'b1111;
                    sdata = reg_b;
                end
            end
            OP_SWL: begin
                memop = 1'b1;
                lanes = MASK_W'((5'd2 << addr[1:0]) - 5'd1);
                sdata = reg_b >> sh8_inv;
            end
            OP_SWR: begin
                memop = 1'b1;
                lanes = MASK_W'(7'h0F << addr[1:0]);
                sdata = reg_b << sh8;
            end
            default: begin
                unk = 1'b1;
            end
        endcase
    end

    assign bit_mask = {{8{lanes[3]}}, {8{lanes[2]}}, {8{lanes[1]}}, {8{lanes[0]}}};
    assign mdata    = (mem_word & ~bit_mask) | (sdata & bit_mask);
    assign mw       = |lanes;
    assign wr_final = wr && (widx != '0);

    always_comb begin
        result = '0;
        if (unk) begin
            result.unknown_opcode = 1'b1;
        end else begin
            result.reg_write_enable = wr_final;
            result.reg_write_index  = wr_final ? widx : '0;
            result.reg_write_value  = wr_final ? wval : '0;
            result.branch_taken     = br;
            result.branch_target    = br ? tgt : '0;
            result.mem_write_enable = mw;
            result.mem_address      = memop ? addr : '0;
            result.mem_write_data   = mw ? mdata : '0;
            result.mem_byte_mask    = mw ? lanes : '0;
        end
    end

endmodule

[src/mips_primary_opcode_execute_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_primary_opcode_execute_top: R3000 primary-opcode execute unit
// immediate ALU ops, branches, jumps, loads and stores over a register file
// and a little-endian data memory
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one instruction per transfer, tdata = {pc, instruction}
//   m_ channel: exactly one result per instruction, in order
//   cfg_wr_en / cfg_wr_data: cache isolation bit, written while idle
// pipeline
//   accept edge reads rs/rt from the register file, the decode stage forms the
//   effective address and reads the data memory, the execute stage then
//   executes, writes back both memories and loads the output register
//   issue: a new instruction is taken only as the previous one retires from
//   execute, set by the register file read / write-back loop; when
//   DATA_WORDS is not a power of two, loads and stores also wait for the
//   word index reduction
// reset
//   the register file reads zero at once; the data memory is cleared by a
//   sweep over all DATA_WORDS words during which s_tready stays low
// stall
//   a held result stays in the output register; one more instruction may
//   advance up to execute, then s_tready drops
// ----------------------------------------------------------------------------
module mips_primary_opcode_execute_top
    import mpoe_pkg::*;
#(
    parameter int DATA_WORDS = MPOE_DATA_WORDS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // instruction [31:0], pc [63:32]
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // reg_write_enable [0], reg_write_index [5:1], reg_write_value [37:6],
    // branch_taken [38], branch_target [70:39], mem_write_enable [71],
    // mem_address [103:72], mem_write_data [135:104], mem_byte_mask [139:136],
    // unknown_opcode [140], zero [143:141]
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // cache_isolated
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data
);

    localparam int RES_W = $bits(result_t);

    // configuration
    logic                 iso_reg;

    // decode stage: operands arriving from the register file
    logic                 s1_valid_reg;
    logic [XLEN-1:0]      s1_ins_reg;
    logic [XLEN-1:0]      s1_pc_reg;

    // execute stage
    logic                 s2_valid_reg;
    logic [XLEN-1:0]      s2_ins_reg;
    logic [XLEN-1:0]      s2_pc_reg;
    logic [XLEN-1:0]      s2_a_reg;
    logic [XLEN-1:0]      s2_b_reg;
    logic                 s2_memop_reg;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [RES_W-1:0]     m_data_reg;

    logic                 s_accept;
    logic                 s2_fire;
    logic [XLEN-1:0]      rf_a;
    logic [XLEN-1:0]      rf_b;
    logic [XLEN-1:0]      s1_addr;
    logic                 s1_memop;
    dm_req_t              dm_req;
    dm_wr_t               dm_wr;
    rf_wr_t               rf_wr;
    logic                 dm_clearing;
    logic                 dm_ready;
    logic [XLEN-1:0]      dm_rdata;
    result_t              exec_res;

    // execute retires when its memory word, if it needs one, is in and the output slot frees
    assign s2_fire  = s2_valid_reg && (!s2_memop_reg || dm_ready) &&
                      (!m_valid_reg || m_tready);
    // next instruction enters as the current one retires, so its register
    // read sees the write-back through the register file bypass
    assign s_tready = !dm_clearing && !s1_valid_reg && (!s2_valid_reg || s2_fire);
    assign s_accept = s_tvalid && s_tready;

    mpoe_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_accept),
        .rd_addr_a (s_tdata[25:21]),
        .rd_addr_b (s_tdata[20:16]),
        .wr        (rf_wr),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b)
    );

    // effective address for the memory read
    assign s1_addr  = rf_a + {{16{s1_ins_reg[15]}}, s1_ins_reg[15:0]};
    assign s1_memop = is_memop(s1_ins_reg[31:26]);

    assign dm_req.valid = s1_valid_reg && s1_memop;
    assign dm_req.word  = s1_addr[XLEN-1:2];

    mpoe_dmem #(
        .DATA_WORDS (DATA_WORDS)
    ) u_dmem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (dm_req),
        .wr       (dm_wr),
        .clearing (dm_clearing),
        .rd_ready (dm_ready),
        .rd_data  (dm_rdata)
    );

    mpoe_exec u_exec (
        .instruction    (s2_ins_reg),
        .pc             (s2_pc_reg),
        .reg_a          (s2_a_reg),
        .reg_b          (s2_b_reg),
        .mem_word       (dm_rdata),
        .cache_isolated (iso_reg),
        .result         (exec_res)
    );

    // write-back
    assign rf_wr.en   = s2_fire && exec_res.reg_write_enable;
    assign rf_wr.addr = exec_res.reg_write_index;
    assign rf_wr.data = exec_res.reg_write_value;
    assign dm_wr.en   = s2_fire && exec_res.mem_write_enable;
    assign dm_wr.data = exec_res.mem_write_data;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s2_fire) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iso_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                iso_reg <= cfg_wr_data;
            end
            s1_valid_reg <= s_accept;
            // decode always advances: execute is empty whenever it holds
            if (s1_valid_reg) begin
                s2_valid_reg <= 1'b1;
            end else if (s2_fire) begin
                s2_valid_reg <= 1'b0;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_ins_reg <= s_tdata[31:0];
            s1_pc_reg  <= s_tdata[63:32];
        end
        if (s1_valid_reg) begin
            s2_ins_reg   <= s1_ins_reg;
            s2_pc_reg    <= s1_pc_reg;
            s2_a_reg     <= rf_a;
            s2_b_reg     <= rf_b;
            s2_memop_reg <= s1_memop;
        end
        if (s2_fire) begin
            m_data_reg <= exec_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - RES_W)'(0), m_data_reg};

endmodule

[src/mpoe_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpoe_checker: port-level checks for the execute unit
// result stream consistency and output handshake behavior
// ----------------------------------------------------------------------------
module mpoe_checker
    import mpoe_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an unhandled opcode reports nothing else
    a_unknown: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[140] |-> m_tdata[139:0] == '0)
        else $error("unknown opcode result carries side effects");

    // register writes never target r0, and no write reports no index
    a_rf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] ? (m_tdata[5:1] != 5'd0) : (m_tdata[37:1] == '0)))
        else $error("register write fields inconsistent");

    // memory write flag agrees with the byte lanes
    a_mw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[71] == (m_tdata[139:136] != 4'd0)))
        else $error("memory write flag and lanes disagree");

    // nothing is shown right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind mips_primary_opcode_execute_top mpoe_checker u_mpoe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: primary-opcode execute block, self-checking
// a queue-fed driver offers instructions on the s_ channel and a clocked
// monitor takes results from the m_ channel; every accepted instruction is
// run through an in-bench model of the register file, the data memory and
// the cache isolation bit, and each result transfer is compared field by
// field with the oldest modeled result
// ----------------------------------------------------------------------------
module testbench;
    import mpoe_pkg::*;

    // opcodes and regimm selectors the block does not decode by name
    localparam logic [OPC_W-1:0]     OP_SPECIAL = 6'h00;
    localparam logic [OPC_W-1:0]     OP_COP0    = 6'h10;
    localparam logic [RF_ADDR_W-1:0] RT_BLTZ    = 5'h00;
    localparam logic [RF_ADDR_W-1:0] RT_BGEZ    = 5'h01;
    localparam logic [RF_ADDR_W-1:0] RT_BLTZAL  = 5'h10;
    localparam logic [RF_ADDR_W-1:0] RT_BGEZAL  = 5'h11;
    localparam int LONG_HOLD_CYCLES = 80;

    // s_tdata layout: instruction in the low word, pc above it
    typedef struct packed {
        logic [XLEN-1:0] pc;
        logic [XLEN-1:0] instruction;
    } exec_item_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic                 cfg_wr_data = 1'b0;

    // architectural state as the block should hold it
    logic [XLEN-1:0] register_model    [RF_DEPTH];
    logic [XLEN-1:0] data_memory_model [MPOE_DATA_WORDS];
    logic            cache_isolated_model;

    exec_item_t instruction_queue[$];
    result_t    executed_results[$];
    exec_item_t offered_item;

    int error_count      = 0;
    int source_idle_pct  = 0;
    int sink_idle_pct    = 0;
    int hold_requests    = 0;
    int holds_granted    = 0;
    int hold_cycles_left = 0;

    mips_primary_opcode_execute_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // instruction model: executes one instruction against the model state
    // and returns the result the block must report for it
    // ------------------------------------------------------------------
    function automatic result_t execute_instruction(input exec_item_t item);
        logic [OPC_W-1:0]     op;
        logic [RF_ADDR_W-1:0] rs, rt, widx;
        logic [15:0]          imm;
        logic [XLEN-1:0]      simm, a, b, addr, btarget, word, v, wval, sdata;
        logic [XLEN-1:0]      lane_mask, merged;
        logic [4:0]           sh8;
        logic [MASK_W-1:0]    lanes;
        logic                 wr, memop, unknown, iso;
        int                   idx;
        result_t              r;

        op      = item.instruction[31:26];
        rs      = item.instruction[25:21];
        rt      = item.instruction[20:16];
        imm     = item.instruction[15:0];
        simm    = {{16{imm[15]}}, imm};
        a       = register_model[rs];
        b       = register_model[rt];
        addr    = a + simm;
        btarget = item.pc + 32'd4 + {simm[29:0], 2'b00};
        sh8     = {addr[1:0], 3'b000};
        word    = data_memory_model[(addr >> 2) % 32'(MPOE_DATA_WORDS)];
        iso     = cache_isolated_model;
        r       = '0;
        wr      = 1'b0;
        memop   = 1'b0;
        unknown = 1'b0;
        widx    = rt;
        wval    = '0;
        lanes   = '0;
        sdata   = '0;

        case (op)
            OP_REGIMM: begin
                // bit zero of rt picks ge or lt; link does not depend on the outcome
                if (a[31] != rt[0]) begin
                    r.branch_taken  = 1'b1;
                    r.branch_target = btarget;
                end
                if ((rt & REGIMM_LINK_MASK) == REGIMM_LINK_CODE) begin
                    wr   = 1'b1;
                    widx = LINK_REG;
                    wval = item.pc + 32'd8;
                end
            end
            OP_J, OP_JAL: begin
                r.branch_taken  = 1'b1;
                r.branch_target = (item.pc & JUMP_REGION_MASK) |
                                  {4'b0000, item.instruction[25:0], 2'b00};
                if (op == OP_JAL) begin
                    wr   = 1'b1;
                    widx = LINK_REG;
                    wval = item.pc + 32'd8;
                end
            end
            OP_BEQ: begin
                if (a == b) begin
                    r.branch_taken  = 1'b1;
                    r.branch_target = btarget;
                end
            end
            OP_BNE: begin
                if (a != b) begin
                    r.branch_taken  = 1'b1;
                    r.branch_target = btarget;
                end
            end
            OP_BLEZ: begin
                if (a[31] || a == '0) begin
                    r.branch_taken  = 1'b1;
                    r.branch_target = btarget;
                end
            end
            OP_BGTZ: begin
                if (!a[31] && a != '0) begin
                    r.branch_taken  = 1'b1;
                    r.branch_target = btarget;
                end
            end
            OP_ADDI, OP_ADDIU: begin
                wr   = 1'b1;
                wval = a + simm;
            end
            OP_SLTI: begin
                wr   = 1'b1;
                wval = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
            end
            OP_SLTIU: begin
                wr   = 1'b1;
                wval = (a < simm) ? 32'd1 : 32'd0;
            end
            OP_ANDI: begin
                wr   = 1'b1;
                wval = a & {16'h0000, imm};
            end
            OP_ORI: begin
                wr   = 1'b1;
                wval = a | {16'h0000, imm};
            end
            OP_XORI: begin
                wr   = 1'b1;
                wval = a ^ {16'h0000, imm};
            end
            OP_LUI: begin
                wr   = 1'b1;
                wval = {imm, 16'h0000};
            end
            OP_LB, OP_LBU: begin
                memop = 1'b1;
                v     = (word >> sh8) & 32'h0000_00FF;
                if (op == OP_LB && v[7]) v = v | 32'hFFFF_FF00;
                wr    = !iso;
                wval  = v;
            end
            OP_LH, OP_LHU: begin
                memop = 1'b1;
                v     = (word >> {addr[1], 4'b0000}) & 32'h0000_FFFF;
                if (op == OP_LH && v[15]) v = v | 32'hFFFF_0000;
                wr    = !iso;
                wval  = v;
            end
            OP_LW: begin
                memop = 1'b1;
                wr    = !iso;
                wval  = word;
            end
            OP_LWL: begin
                memop = 1'b1;
                wr    = 1'b1;
                wval  = (b & (32'h00FF_FFFF >> sh8)) | (word << (5'd24 - sh8));
            end
            OP_LWR: begin
                memop = 1'b1;
                wr    = 1'b1;
                wval  = (b & (32'hFFFF_FF00 << (5'd24 - sh8))) | (word >> sh8);
            end
            OP_SB: begin
                memop = 1'b1;
                if (!iso) begin
                    lanes = 4'b0001 << addr[1:0];
                    sdata = b << sh8;
                end
            end
            OP_SH: begin
                memop = 1'b1;
                if (!iso) begin
                    lanes = 4'b0011 << {addr[1], 1'b0};
                    sdata = b << {addr[1], 4'b0000};
                end
            end
            OP_SW: begin
                memop = 1'b1;
                if (!iso) begin
                    lanes = 4'b1111;
                    sdata = b;
                end
            end
            // unaligned stores act even with the cache isolated
            OP_SWL: begin
                memop = 1'b1;
                lanes = 4'b1111 >> (2'd3 - addr[1:0]);
                sdata = b >> (5'd24 - sh8);
            end
            OP_SWR: begin
                memop = 1'b1;
                lanes = 4'b1111 << addr[1:0];
                sdata = b << sh8;
            end
            default: begin
                unknown = 1'b1;
            end
        endcase

        if (unknown) begin
            r                = '0;
            r.unknown_opcode = 1'b1;
            return r;
        end

        if (lanes != '0) begin
            lane_mask = '0;
            for (int i = 0; i < MASK_W; i++) begin
                if (lanes[i]) lane_mask[8*i +: 8] = 8'hFF;
            end
            idx    = int'((addr >> 2) % 32'(MPOE_DATA_WORDS));
            merged = (data_memory_model[idx] & ~lane_mask) | (sdata & lane_mask);
            data_memory_model[idx] = merged;
            r.mem_write_enable = 1'b1;
            r.mem_write_data   = merged;
            r.mem_byte_mask    = lanes;
        end

        // r0 is hardwired, a write to it is dropped
        if (wr && widx == '0) wr = 1'b0;
        if (wr) begin
            register_model[widx] = wval;
            r.reg_write_enable   = 1'b1;
            r.reg_write_index    = widx;
            r.reg_write_value    = wval;
        end
        if (memop) r.mem_address = addr;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [XLEN-1:0] want,
                                        input logic [XLEN-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            error_count++;
        end
    endfunction

    task automatic compare_result(input logic [M_TDATA_W-1:0] word);
        result_t got;
        result_t want;
        got = result_t'(word[$bits(result_t)-1:0]);
        if (executed_results.size() == 0) begin
            $error("result transfer with no instruction outstanding");
            error_count++;
            return;
        end
        want = executed_results.pop_front();
        check_field("reg_write_enable", 32'(want.reg_write_enable), 32'(got.reg_write_enable));
        check_field("reg_write_index", 32'(want.reg_write_index), 32'(got.reg_write_index));
        check_field("reg_write_value", want.reg_write_value, got.reg_write_value);
        check_field("branch_taken", 32'(want.branch_taken), 32'(got.branch_taken));
        check_field("branch_target", want.branch_target, got.branch_target);
        check_field("mem_write_enable", 32'(want.mem_write_enable), 32'(got.mem_write_enable));
        check_field("mem_address", want.mem_address, got.mem_address);
        check_field("mem_write_data", want.mem_write_data, got.mem_write_data);
        check_field("mem_byte_mask", 32'(want.mem_byte_mask), 32'(got.mem_byte_mask));
        check_field("unknown_opcode", 32'(want.unknown_opcode), 32'(got.unknown_opcode));
        check_field("tdata padding", '0, 32'(word[M_TDATA_W-1:$bits(result_t)]));
    endtask

    // ------------------------------------------------------------------
    // driver: offers queued instructions, models each one as it transfers
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                executed_results.push_back(execute_instruction(offered_item));
            end
            // slot is free when nothing is offered or the offer just went through
            if (!s_tvalid || s_tready) begin
                if (instruction_queue.size() != 0 &&
                    $urandom_range(99) >= source_idle_pct) begin
                    offered_item = instruction_queue.pop_front();
                    s_tdata  <= offered_item;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks result transfers, random back-pressure and long holds
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) compare_result(m_tdata);
            if (hold_cycles_left > 0) begin
                hold_cycles_left--;
                m_tready <= 1'b0;
            end else if (holds_granted != hold_requests) begin
                // long hold so the block fills up and drops s_tready
                holds_granted++;
                hold_cycles_left = LONG_HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // instruction building
    // ------------------------------------------------------------------
    function automatic logic [XLEN-1:0] i_type(input logic [OPC_W-1:0] op,
                                               input logic [RF_ADDR_W-1:0] rs,
                                               input logic [RF_ADDR_W-1:0] rt,
                                               input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [XLEN-1:0] j_type(input logic [OPC_W-1:0] op,
                                               input logic [25:0] target);
        return {op, target};
    endfunction

    function automatic logic [XLEN-1:0] random_pc();
        case ($urandom_range(19))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'hFFFF_FFFC;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] random_immediate();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [OPC_W-1:0] alu_op(input int k);
        case (k)
            0: return OP_ADDI;
            1: return OP_ADDIU;
            2: return OP_SLTI;
            3: return OP_SLTIU;
            4: return OP_ANDI;
            5: return OP_ORI;
            6: return OP_XORI;
            default: return OP_LUI;
        endcase
    endfunction

    function automatic logic [OPC_W-1:0] branch_op(input int k);
        case (k)
            0: return OP_BEQ;
            1: return OP_BNE;
            2: return OP_BLEZ;
            3: return OP_BGTZ;
            default: return OP_REGIMM;
        endcase
    endfunction

    function automatic logic [OPC_W-1:0] memory_op(input int k);
        case (k)
            0: return OP_LB;
            1: return OP_LH;
            2: return OP_LWL;
            3: return OP_LW;
            4: return OP_LBU;
            5: return OP_LHU;
            6: return OP_LWR;
            7: return OP_SB;
            8: return OP_SH;
            9: return OP_SWL;
            10: return OP_SW;
            default: return OP_SWR;
        endcase
    endfunction

    function automatic void push_item(input logic [XLEN-1:0] instruction,
                                      input logic [XLEN-1:0] pc);
        exec_item_t item;
        item.instruction = instruction;
        item.pc          = pc;
        instruction_queue.push_back(item);
    endfunction

    function automatic logic [RF_ADDR_W-1:0] random_reg();
        return RF_ADDR_W'($urandom_range(31));
    endfunction

    // one random group: a register load, a single op, or a burst of memory
    // accesses around a freshly set base register
    function automatic void push_random_group();
        logic [RF_ADDR_W-1:0] base_reg, rs, rt;
        logic [15:0]          offset;
        int                   kind, burst;
        kind = $urandom_range(99);
        if (kind < 10) begin
            rt = random_reg();
            push_item(i_type(OP_LUI, '0, rt, random_immediate()), random_pc());
            push_item(i_type(OP_ORI, rt, rt, random_immediate()), random_pc());
        end else if (kind < 35) begin
            push_item(i_type(alu_op($urandom_range(7)), random_reg(), random_reg(),
                             random_immediate()), random_pc());
        end else if (kind < 50) begin
            push_item(i_type(branch_op($urandom_range(5)), random_reg(), random_reg(),
                             random_immediate()), random_pc());
        end else if (kind < 55) begin
            push_item(j_type($urandom_range(1) ? OP_JAL : OP_J, 26'($urandom)), random_pc());
        end else if (kind < 92) begin
            base_reg = RF_ADDR_W'($urandom_range(1, 31));
            push_item(i_type(OP_ADDIU, '0, base_reg, random_immediate()), random_pc());
            burst = $urandom_range(2, 6);
            for (int i = 0; i < burst; i++) begin
                rs     = ($urandom_range(9) == 0) ? random_reg() : base_reg;
                rt     = random_reg();
                offset = ($urandom_range(9) == 0) ? random_immediate()
                                                  : 16'($urandom_range(15) - 8);
                push_item(i_type(memory_op($urandom_range(11)), rs, rt, offset),
                          random_pc());
            end
        end else begin
            // raw noise: unknown opcodes, special and coprocessor words
            push_item($urandom, random_pc());
        end
    endfunction

    // ------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------
    task automatic wait_until_drained();
        do begin
            @(negedge aclk);
        end while (instruction_queue.size() != 0 || s_tvalid || executed_results.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_cache_isolation(input logic value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cache_isolated_model = value;
        @(negedge aclk);
    endtask

    task automatic run_random_phase(input logic iso, input int src_pct, input int snk_pct,
                                    input int count, input bit long_hold);
        // sender pauses here until every modeled result has transferred
        wait_until_drained();
        write_cache_isolation(iso);
        source_idle_pct = src_pct;
        sink_idle_pct   = snk_pct;
        while (instruction_queue.size() < count) push_random_group();
        if (long_hold) hold_requests++;
    endtask

    initial begin
        foreach (register_model[i]) register_model[i] = '0;
        foreach (data_memory_model[i]) data_memory_model[i] = '0;
        cache_isolated_model = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        write_cache_isolation(1'b0);
        source_idle_pct = 36;
        sink_idle_pct   = 50;

        // directed part
        push_item(i_type(OP_LUI, '0, 5'd1, 16'h7FFF), random_pc());
        push_item(i_type(OP_ORI, 5'd1, 5'd1, 16'hFFFF), random_pc());
        // addi past the positive limit wraps without a trap
        push_item(i_type(OP_ADDI, 5'd1, 5'd2, 16'h0001), random_pc());
        // write to r0 is dropped
        push_item(i_type(OP_ADDIU, 5'd1, '0, 16'h0005), random_pc());
        push_item(i_type(OP_SLTI, 5'd2, 5'd3, 16'h8000), random_pc());
        push_item(i_type(OP_SLTIU, 5'd1, 5'd4, 16'hFFFF), random_pc());
        push_item(i_type(OP_ANDI, 5'd1, 5'd5, 16'h8000), random_pc());
        push_item(i_type(OP_XORI, 5'd2, 5'd6, 16'hFFFF), random_pc());
        // address one memory size up aliases onto word zero
        push_item(i_type(OP_SW, '0, 5'd1, 16'h1000), random_pc());
        // misaligned halfword and word accesses drop the low address bits
        push_item(i_type(OP_SH, '0, 5'd6, 16'h0003), random_pc());
        push_item(i_type(OP_LW, '0, 5'd7, 16'h0002), random_pc());
        push_item(i_type(OP_LB, '0, 5'd8, 16'h0002), random_pc());
        push_item(i_type(OP_LBU, '0, 5'd9, 16'h0003), random_pc());
        push_item(i_type(OP_LH, '0, 5'd10, 16'h0003), random_pc());
        push_item(i_type(OP_LHU, '0, 5'd11, 16'h0001), random_pc());
        push_item(i_type(OP_SB, '0, 5'd2, 16'hFFFF), random_pc());
        push_item(i_type(OP_SWL, '0, 5'd2, 16'h0001), random_pc());
        push_item(i_type(OP_SWR, '0, 5'd1, 16'h0002), random_pc());
        push_item(i_type(OP_LWL, '0, 5'd12, 16'h0003), random_pc());
        push_item(i_type(OP_LWR, '0, 5'd12, 16'h0000), random_pc());
        push_item(i_type(OP_BEQ, 5'd1, 5'd1, 16'hFFFF), 32'h0000_0000);
        push_item(i_type(OP_BNE, '0, '0, 16'h7FFF), random_pc());
        // blez and bgtz ignore rt
        push_item(i_type(OP_BLEZ, '0, 5'd5, 16'h8000), random_pc());
        push_item(i_type(OP_BGTZ, 5'd1, 5'd31, 16'h0004), random_pc());
        // link lands in r31; the second branch tests r31 as it was before its own link
        push_item(i_type(OP_REGIMM, '0, RT_BGEZAL, 16'h0010), 32'hFFFF_FFFC);
        push_item(i_type(OP_REGIMM, 5'd31, RT_BLTZAL, 16'hFFF0), random_pc());
        push_item(i_type(OP_REGIMM, 5'd2, RT_BLTZ, 16'h0001), random_pc());
        push_item(i_type(OP_REGIMM, 5'd2, RT_BGEZ, 16'h0001), random_pc());
        push_item(j_type(OP_J, 26'h3FF_FFFF), 32'hFFFF_FFFF);
        push_item(j_type(OP_JAL, 26'h000_0000), random_pc());
        // special and coprocessor words are not handled
        push_item(i_type(OP_SPECIAL, '0, '0, 16'h0000), random_pc());
        push_item(i_type(OP_COP0, 5'h10, '0, 16'h0010), random_pc());

        // random part: idle mix, then swapped mix, then no idling
        run_random_phase(1'b0, 36, 50, 400, 1'b1);
        run_random_phase(1'b1, 50, 36, 400, 1'b0);
        run_random_phase(1'b0, 0, 0, 300, 1'b1);
        run_random_phase(1'b1, 0, 0, 100, 1'b0);

        wait_until_drained();
        repeat (40) @(posedge aclk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // run time limit, well past the slowest legal run including the memory clear
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
